// File: sv/lph_pkg.sv
// shared constants, types and codes of the linear probing hash table
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

	// table geometry
	localparam int MAX_SLOTS = 1024;
	localparam int KEY_BITS  = 64;
	localparam int SLOT_AW   = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_AW + 1;

	// port field widths
	localparam int CMD_W     = 2;
	localparam int KEY_W     = 64;
	localparam int HASH_BITS = 32;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int LIVE_W    = 11;
	localparam int CFG_W     = 11;

	// slot count register
	localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(15);
	localparam int MIN_SLOTS = 2;

	// remainder unit: quotient bits retired per cycle
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_CYCLES     = HASH_BITS / DIV_RADIX_BITS;
	localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

	// commands
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// slot marks
	localparam int MARK_W = 2;
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [HASH_BITS-1:0] hash;
		logic [VAL_W-1:0]     value;
	} slot_entry_t;

	typedef struct packed {
		logic [SLOT_AW-1:0] rd_addr;
		logic [SLOT_AW-1:0] wr_addr;
		logic               mark_we;
		logic [MARK_W-1:0]  wr_mark;
		logic               entry_we;
		slot_entry_t        wr_entry;
	} mem_req_t;

	typedef struct packed {
		logic [MARK_W-1:0] mark;
		slot_entry_t       entry;
	} mem_rsp_t;

endpackage

`default_nettype wire

// File: sv/lph_req_if.sv
// request channel: one get, put or remove
`timescale 1ns / 1ps
`default_nettype none

interface lph_req_if;
	logic                           valid;
	logic                           ready;
	logic [lph_pkg::CMD_W-1:0]      cmd;
	logic [lph_pkg::KEY_W-1:0]      key_word;
	logic [lph_pkg::HASH_BITS-1:0]  key_hash;
	logic [lph_pkg::VAL_W-1:0]      value_in;

	modport source (output valid, output cmd, output key_word, output key_hash,
		output value_in, input ready);
	modport sink (input valid, input cmd, input key_word, input key_hash,
		input value_in, output ready);
endinterface

`default_nettype wire

// File: sv/lph_rsp_if.sv
// result channel: status, value and live count
`timescale 1ns / 1ps
`default_nettype none

interface lph_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lph_pkg::STATUS_W-1:0]  status;
	logic [lph_pkg::VAL_W-1:0]     value_out;
	logic [lph_pkg::LIVE_W-1:0]    live_entries;

	modport source (output valid, output status, output value_out,
		output live_entries, input ready);
	modport sink (input valid, input status, input value_out,
		input live_entries, output ready);
endinterface

`default_nettype wire

// File: sv/lph_cfg_if.sv
// configuration write channel for the slot count register
`timescale 1ns / 1ps
`default_nettype none

interface lph_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lph_pkg::CFG_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/lph_mod_div.sv
// iterative remainder unit: hash modulo slot count, two bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module lph_mod_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lph_pkg::HASH_BITS-1:0]  dividend,
	input  wire logic [lph_pkg::CNT_W-1:0]      divisor,
	output logic                                done,
	output logic [lph_pkg::SLOT_AW-1:0]         remainder
);

	logic                           busy_q;
	logic                           done_q;
	logic [lph_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [lph_pkg::HASH_BITS-1:0]  dvd_q;
	logic [lph_pkg::CNT_W-1:0]      dvs_q;
	logic [lph_pkg::CNT_W-1:0]      rem_q;
	logic [lph_pkg::HASH_BITS-1:0]  dvd_nx;
	logic [lph_pkg::CNT_W-1:0]      rem_nx;

	// restoring steps, one per quotient bit
	always_comb begin
		logic [lph_pkg::CNT_W-1:0]      r;
		logic [lph_pkg::HASH_BITS-1:0]  d;
		logic [lph_pkg::CNT_W:0]        t;
		r = rem_q;
		d = dvd_q;
		t = '0;
		for (int i = 0; i < lph_pkg::DIV_RADIX_BITS; i++) begin
			t = {r, d[lph_pkg::HASH_BITS-1]};
			d = d << 1;
			if (t >= {1'b0, dvs_q})
				t = t - {1'b0, dvs_q};
			r = t[lph_pkg::CNT_W-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lph_pkg::DIV_CNT_W'(lph_pkg::DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[lph_pkg::SLOT_AW-1:0];

endmodule

`default_nettype wire

// File: sv/lph_slot_mem.sv
// slot storage: mark memory with clearing pass and key/hash/value memory
`timescale 1ns / 1ps
`default_nettype none

module lph_slot_mem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lph_pkg::mem_req_t  req,
	output lph_pkg::mem_rsp_t       rsp,
	output logic                    busy
);

	logic [lph_pkg::MARK_W-1:0]  mark_mem [lph_pkg::MAX_SLOTS];
	lph_pkg::slot_entry_t        entry_mem [lph_pkg::MAX_SLOTS];

	logic                          clr_busy_q;
	logic [lph_pkg::SLOT_AW-1:0]   clr_addr_q;
	logic [lph_pkg::MARK_W-1:0]    mark_rd_q;
	lph_pkg::slot_entry_t          entry_rd_q;

	// clearing pass over the marks after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == lph_pkg::SLOT_AW'(lph_pkg::MAX_SLOTS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// mark memory
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mark_mem[clr_addr_q] <= lph_pkg::MARK_EMPTY;
		else if (req.mark_we)
			mark_mem[req.wr_addr] <= req.wr_mark;
		mark_rd_q <= mark_mem[req.rd_addr];
	end

	// key, hash and value memory
	always_ff @(posedge clk) begin
		if (req.entry_we)
			entry_mem[req.wr_addr] <= req.wr_entry;
		entry_rd_q <= entry_mem[req.rd_addr];
	end

	assign rsp.mark  = mark_rd_q;
	assign rsp.entry = entry_rd_q;
	assign busy      = clr_busy_q;

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_table.sv
// Linear probing hash table with tombstones, one request at a time.
// Get on an empty table, put at half load and the unused command skip the remainder
// unit and the probe and go straight to the result stage; other requests first take
// the probe start slot from the remainder unit, then probe one slot per cycle through
// the slot memories. A new request is taken only once the result is registered.
// Reset: counts clear, slot count is 15; a pass over all 1024 slot marks clears them,
// during which no request is taken (configuration writes are).
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lph_req_if.sink    req,
	lph_rsp_if.source  rsp,
	lph_cfg_if.sink    cfg
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_PROBE  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0]                        state_q;
	logic [lph_pkg::CFG_W-1:0]         slot_count_q;
	logic [lph_pkg::LIVE_W-1:0]        live_q;
	logic [lph_pkg::LIVE_W-1:0]        used_q;

	logic [lph_pkg::CMD_W-1:0]         cmd_q;
	logic [lph_pkg::KEY_BITS-1:0]      key_q;
	logic [lph_pkg::HASH_BITS-1:0]     hash_q;
	logic [lph_pkg::VAL_W-1:0]         val_q;
	logic [lph_pkg::SLOT_AW-1:0]       idx_q;
	logic [lph_pkg::CNT_W-1:0]         step_q;
	logic [lph_pkg::SLOT_AW-1:0]       tomb_q;
	logic                              tomb_valid_q;
	logic [lph_pkg::STATUS_W-1:0]      res_status_q;
	logic [lph_pkg::VAL_W-1:0]         res_value_q;

	logic                              rsp_valid_q;
	logic [lph_pkg::STATUS_W-1:0]      rsp_status_q;
	logic [lph_pkg::VAL_W-1:0]         rsp_value_q;
	logic [lph_pkg::LIVE_W-1:0]        rsp_live_q;

	logic [lph_pkg::CNT_W-1:0]         n_slots;
	logic [lph_pkg::LIVE_W-1:0]        half_slots;
	logic                              req_fire;
	logic                              short_op;
	logic [lph_pkg::STATUS_W-1:0]      short_status;
	logic                              div_done;
	logic [lph_pkg::SLOT_AW-1:0]       div_rem;
	lph_pkg::mem_req_t                 mem_req;
	lph_pkg::mem_rsp_t                 mem_rsp;
	logic                              mem_busy;

	logic [lph_pkg::SLOT_AW-1:0]       next_idx;
	logic                              is_empty;
	logic                              is_live;
	logic                              is_match;
	logic                              is_last;
	logic                              resolve;
	logic                              spot_valid;
	logic [lph_pkg::SLOT_AW-1:0]       spot_idx;
	logic                              spot_was_empty;
	logic                              live_inc;
	logic                              live_dec;
	logic                              used_inc;
	logic [lph_pkg::STATUS_W-1:0]      probe_status;
	logic [lph_pkg::VAL_W-1:0]         probe_value;
	logic                              out_free;

	// effective slot count, clamped to the supported range
	always_comb begin
		if (int'(slot_count_q) < lph_pkg::MIN_SLOTS)
			n_slots = lph_pkg::CNT_W'(lph_pkg::MIN_SLOTS);
		else if (int'(slot_count_q) > lph_pkg::MAX_SLOTS)
			n_slots = lph_pkg::CNT_W'(lph_pkg::MAX_SLOTS);
		else
			n_slots = lph_pkg::CNT_W'(slot_count_q);
	end
	assign half_slots = lph_pkg::LIVE_W'(n_slots >> 1);

	// request side
	assign req.ready = (state_q == ST_IDLE) && !mem_busy;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// requests answered without a probe
	always_comb begin
		short_op     = 1'b0;
		short_status = lph_pkg::STATUS_MISS;
		case (req.cmd)
			lph_pkg::CMD_GET: begin
				short_op = (live_q == '0);
			end
			lph_pkg::CMD_PUT: begin
				short_op     = (used_q >= half_slots);
				short_status = lph_pkg::STATUS_FULL;
			end
			lph_pkg::CMD_REMOVE: begin
				short_op = 1'b0;
			end
			default: begin
				short_op = 1'b1;
			end
		endcase
	end

	// probe start slot
	lph_mod_div u_mod_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_fire && !short_op),
		.dividend  (req.key_hash),
		.divisor   (n_slots),
		.done      (div_done),
		.remainder (div_rem)
	);

	// probe step evaluation on the slot read back this cycle
	always_comb begin
		next_idx = (({1'b0, idx_q} + 1'b1) == n_slots) ? '0 : idx_q + 1'b1;
		is_empty = (mem_rsp.mark == lph_pkg::MARK_EMPTY);
		is_live  = (mem_rsp.mark == lph_pkg::MARK_LIVE);
		is_match = is_live && (mem_rsp.entry.key == key_q) && (mem_rsp.entry.hash == hash_q);
		is_last  = ((step_q + 1'b1) == n_slots);
		resolve  = (state_q == ST_PROBE) && (is_empty || is_match || is_last);
		if (is_empty) begin
			spot_valid     = 1'b1;
			spot_idx       = tomb_valid_q ? tomb_q : idx_q;
			spot_was_empty = !tomb_valid_q;
		end else begin
			spot_valid     = tomb_valid_q || !is_live;
			spot_idx       = tomb_valid_q ? tomb_q : idx_q;
			spot_was_empty = 1'b0;
		end
	end

	// slot read address, and outcome and memory writes of a finished probe
	always_comb begin
		mem_req          = '0;
		mem_req.rd_addr  = (state_q == ST_DIV) ? div_rem : next_idx;
		mem_req.wr_entry = '{key: key_q, hash: hash_q, value: val_q};
		live_inc         = 1'b0;
		live_dec         = 1'b0;
		used_inc         = 1'b0;
		probe_status     = lph_pkg::STATUS_MISS;
		probe_value      = '0;
		if (resolve) begin
			case (cmd_q)
				lph_pkg::CMD_GET: begin
					if (is_match) begin
						probe_status = lph_pkg::STATUS_OK;
						probe_value  = mem_rsp.entry.value;
					end
				end
				lph_pkg::CMD_PUT: begin
					if (is_match) begin
						mem_req.entry_we = 1'b1;
						mem_req.wr_addr  = idx_q;
						probe_status     = lph_pkg::STATUS_OK;
					end else if (spot_valid) begin
						mem_req.entry_we = 1'b1;
						mem_req.mark_we  = 1'b1;
						mem_req.wr_addr  = spot_idx;
						mem_req.wr_mark  = lph_pkg::MARK_LIVE;
						live_inc         = 1'b1;
						used_inc         = spot_was_empty;
						probe_status     = lph_pkg::STATUS_OK;
					end else begin
						probe_status = lph_pkg::STATUS_FULL;
					end
				end
				lph_pkg::CMD_REMOVE: begin
					if (is_match) begin
						mem_req.mark_we = 1'b1;
						mem_req.wr_addr = idx_q;
						mem_req.wr_mark = lph_pkg::MARK_TOMB;
						live_dec        = (live_q != '0);
						probe_status    = lph_pkg::STATUS_OK;
					end
				end
				default: begin
					probe_status = lph_pkg::STATUS_MISS;
				end
			endcase
		end
	end

	lph_slot_mem u_slot_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp),
		.busy   (mem_busy)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	// sequencer, counts, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_count_q <= lph_pkg::COUNT_RESET;
			live_q       <= '0;
			used_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid)
				slot_count_q <= cfg.data;
			if (live_inc)
				live_q <= live_q + 1'b1;
			else if (live_dec)
				live_q <= live_q - 1'b1;
			if (used_inc)
				used_q <= used_q + 1'b1;
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_fire)
						state_q <= short_op ? ST_RESULT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (resolve)
						state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, probe bookkeeping and output payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q        <= req.cmd;
			key_q        <= req.key_word[lph_pkg::KEY_BITS-1:0];
			hash_q       <= req.key_hash;
			val_q        <= req.value_in;
			res_status_q <= short_status;
			res_value_q  <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			idx_q        <= div_rem;
			step_q       <= '0;
			tomb_valid_q <= 1'b0;
		end
		if (state_q == ST_PROBE) begin
			if (resolve) begin
				res_status_q <= probe_status;
				res_value_q  <= probe_value;
			end else begin
				idx_q  <= next_idx;
				step_q <= step_q + 1'b1;
				if (!tomb_valid_q && !is_live && !is_empty) begin
					tomb_q       <= idx_q;
					tomb_valid_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_RESULT && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
			rsp_live_q   <= live_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.value_out    = rsp_value_q;
	assign rsp.live_entries = rsp_live_q;

	// no request taken during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n) mem_busy |-> !req.ready)
		else $error("request accepted while slot marks are being cleared");

	// live keys never outnumber used slots
	assert property (@(posedge clk) disable iff (!arst_n) live_q <= used_q)
		else $error("live count exceeds used count");

	// slot memories are written only when a probe finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.mark_we || mem_req.entry_we) |-> resolve)
		else $error("slot write outside a finished probe");

	// a finished probe always hands over to the result stage
	assert property (@(posedge clk) disable iff (!arst_n)
		resolve |=> (state_q == ST_RESULT))
		else $error("finished probe did not reach the result stage");

endmodule

`default_nettype wire
